[rtl/pcc_pkg.sv]
// ----------------------------------------------------------------------------
// Pearson correlation package
// Shared constants, width helpers and control types for the correlation unit.
// ----------------------------------------------------------------------------
package pcc_pkg;

  // Limb and word sizes of the back-end arithmetic.
  localparam int LIMB_W = 32;
  localparam int WORD_W = 64;
  localparam int WIDE_W = 128;
  localparam int ACC_W  = 160;

  // Result format.
  localparam int R_W      = 16;
  localparam int STATUS_W = 2;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_ZERO_VAR = 2'd1;
  localparam logic [STATUS_W-1:0] ST_TOO_MANY = 2'd2;

  // Search bounds for the magnitude of r scaled by 2^15.
  localparam logic [R_W-1:0] SEARCH_HI = 16'd32768;
  localparam logic [R_W-1:0] R_MAX     = 16'd32767;

  // Depth of the queue between front and back (a power of two).
  localparam int QUEUE_DEPTH = 2;

  // Back-end sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_ACC,
    S_STORE,
    S_CHECK,
    S_SEARCH,
    S_DONE
  } back_state_t;

  // Multiply jobs run on the shared limb multiplier.
  typedef enum logic [2:0] {
    JOB_C,
    JOB_A,
    JOB_B,
    JOB_AB,
    JOB_CC,
    JOB_T,
    JOB_L
  } job_t;

  // Width of the pair counter.
  function automatic int cnt_w(input int max_samples);
    return $clog2(max_samples + 1);
  endfunction

  // Width of the signed sums of x and y.
  function automatic int sx_w(input int sample_bits, input int max_samples);
    return sample_bits + $clog2(max_samples) + 1;
  endfunction

  // Width of the unsigned sums of squares.
  function automatic int sq_w(input int sample_bits, input int max_samples);
    return 2 * sample_bits - 1 + $clog2(max_samples);
  endfunction

  // Width of the signed sum of cross products.
  function automatic int xy_w(input int sample_bits, input int max_samples);
    return 2 * sample_bits + $clog2(max_samples);
  endfunction

  // Width of one series snapshot passed from front to back.
  function automatic int snap_w(input int sample_bits, input int max_samples);
    return 1 + cnt_w(max_samples) + 2 * sx_w(sample_bits, max_samples)
           + 2 * sq_w(sample_bits, max_samples) + xy_w(sample_bits, max_samples);
  endfunction

endpackage

[rtl/pcc_front.sv]
// ----------------------------------------------------------------------------
// Pearson correlation front end
// Forms the sample products, keeps the running sums and hands a snapshot of
// each finished series to the queue.
// ----------------------------------------------------------------------------
module pcc_front #(
  parameter int MAX_SAMPLES = 1024,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                              clk,
  input  logic                                              rst,
  input  logic                                              in_valid,
  output logic                                              in_stall,
  input  logic signed [15:0]                                x_sample,
  input  logic signed [15:0]                                y_sample,
  input  logic                                              last,
  output logic                                              push,
  output logic [pcc_pkg::snap_w(SAMPLE_BITS, MAX_SAMPLES)-1:0] push_data,
  input  logic                                              q_full
);
  import pcc_pkg::*;

  localparam int CNT_W  = cnt_w(MAX_SAMPLES);
  localparam int SX_W   = sx_w(SAMPLE_BITS, MAX_SAMPLES);
  localparam int SQ_W   = sq_w(SAMPLE_BITS, MAX_SAMPLES);
  localparam int XY_W   = xy_w(SAMPLE_BITS, MAX_SAMPLES);
  localparam int PSQ_W  = 2 * SAMPLE_BITS - 1;
  localparam int PXY_W  = 2 * SAMPLE_BITS;

  logic signed [SAMPLE_BITS-1:0] xs, ys;
  logic signed [PXY_W-1:0]       xx_full, yy_full, xy_full;

  // Product stage registers.
  logic                          p_valid;
  logic                          p_last;
  logic signed [SAMPLE_BITS-1:0] p_x, p_y;
  logic [PSQ_W-1:0]              p_xx, p_yy;
  logic signed [PXY_W-1:0]       p_xy;

  // Accumulators.
  logic [CNT_W-1:0]        cnt, cnt_next;
  logic signed [SX_W-1:0]  sx, sx_next, sy, sy_next;
  logic [SQ_W-1:0]         sxx, sxx_next, syy, syy_next;
  logic signed [XY_W-1:0]  sxy, sxy_next;
  logic                    ovf, ovf_next;
  logic                    advance;

  // Samples are taken at SAMPLE_BITS and sign-extended from there.
  assign xs = $signed(SAMPLE_BITS'($unsigned(x_sample)));
  assign ys = $signed(SAMPLE_BITS'($unsigned(y_sample)));
  assign xx_full = xs * xs;
  assign yy_full = ys * ys;
  assign xy_full = xs * ys;

  // The only hold-up is a finished series that finds the queue full.
  assign in_stall = p_valid && p_last && q_full;
  assign advance  = !in_stall;
  assign push     = p_valid && p_last && !q_full;

  // Product stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (advance) begin
      p_valid <= in_valid;
    end
    if (advance && in_valid) begin
      p_last <= last;
      p_x    <= xs;
      p_y    <= ys;
      p_xx   <= PSQ_W'($unsigned(xx_full));
      p_yy   <= PSQ_W'($unsigned(yy_full));
      p_xy   <= xy_full;
    end
  end

  // Next accumulator values; a pair past the limit only raises the flag.
  always_comb begin
    cnt_next = cnt;
    sx_next  = sx;
    sy_next  = sy;
    sxx_next = sxx;
    syy_next = syy;
    sxy_next = sxy;
    ovf_next = ovf;
    if (p_valid) begin
      if (cnt >= CNT_W'(MAX_SAMPLES)) begin
        ovf_next = 1'b1;
      end else begin
        cnt_next = cnt + 1'b1;
        sx_next  = sx + SX_W'(p_x);
        sy_next  = sy + SX_W'(p_y);
        sxx_next = sxx + SQ_W'(p_xx);
        syy_next = syy + SQ_W'(p_yy);
        sxy_next = sxy + XY_W'(p_xy);
      end
    end
  end

  assign push_data = {ovf_next, cnt_next, sx_next, sy_next, sxx_next, syy_next, sxy_next};

  // Accumulator registers clear after the last pair of a series.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      sx  <= '0;
      sy  <= '0;
      sxx <= '0;
      syy <= '0;
      sxy <= '0;
      ovf <= 1'b0;
    end else if (advance) begin
      if (p_valid && p_last) begin
        cnt <= '0;
        sx  <= '0;
        sy  <= '0;
        sxx <= '0;
        syy <= '0;
        sxy <= '0;
        ovf <= 1'b0;
      end else begin
        cnt <= cnt_next;
        sx  <= sx_next;
        sy  <= sy_next;
        sxx <= sxx_next;
        syy <= syy_next;
        sxy <= sxy_next;
        ovf <= ovf_next;
      end
    end
  end

endmodule

[rtl/pcc_queue.sv]
// ----------------------------------------------------------------------------
// Pearson correlation series queue
// Short first-in first-out buffer of series snapshots between front and back.
// ----------------------------------------------------------------------------
module pcc_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  output logic             valid,
  output logic [WIDTH-1:0] head,
  input  logic             pop
);
  import pcc_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] slot [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign full  = count == CNT_W'(QUEUE_DEPTH);
  assign valid = count != '0;
  assign head  = slot[rd_ptr];

  // Pointers wrap naturally since the depth is a power of two.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= push_data;
    end
  end

endmodule

[rtl/pcc_back.sv]
// ----------------------------------------------------------------------------
// Pearson correlation back end
// Forms C, A and B in 64-bit wrapping arithmetic on one shared 32x32
// multiplier, then binary-searches the rounded Q1.15 magnitude of r.
// ----------------------------------------------------------------------------
module pcc_back #(
  parameter int MAX_SAMPLES = 1024,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                              clk,
  input  logic                                              rst,
  input  logic                                              q_valid,
  input  logic [pcc_pkg::snap_w(SAMPLE_BITS, MAX_SAMPLES)-1:0] q_data,
  output logic                                              q_pop,
  output logic                                              out_valid,
  input  logic                                              out_stall,
  output logic signed [pcc_pkg::R_W-1:0]                    r_value,
  output logic [pcc_pkg::STATUS_W-1:0]                      status
);
  import pcc_pkg::*;

  localparam int CNT_W = cnt_w(MAX_SAMPLES);
  localparam int SX_W  = sx_w(SAMPLE_BITS, MAX_SAMPLES);
  localparam int SQ_W  = sq_w(SAMPLE_BITS, MAX_SAMPLES);
  localparam int XY_W  = xy_w(SAMPLE_BITS, MAX_SAMPLES);

  // Snapshot fields.
  logic                   s_ovf;
  logic [CNT_W-1:0]       s_cnt;
  logic signed [SX_W-1:0] s_sx, s_sy;
  logic [SQ_W-1:0]        s_sxx, s_syy;
  logic signed [XY_W-1:0] s_sxy;
  logic [WORD_W-1:0]      n64, sx64, sy64, sxx64, syy64, sxy64;

  back_state_t state, state_next;
  job_t        job;
  logic [2:0]  term;

  // Datapath registers.
  logic [WORD_W-1:0]   prod;
  logic [ACC_W-1:0]    acc;
  logic [WORD_W-1:0]   c_word, a_word, b_word, mag;
  logic                neg;
  logic [WIDE_W-1:0]   ab, cc;
  logic [LIMB_W-1:0]   t_word;
  logic [R_W-1:0]      lo, hi, mid;
  logic [STATUS_W-1:0] res_status;

  // Operand selection.
  logic [WORD_W-1:0] wp, wq, wu, wv;
  logic [LIMB_W-1:0] opa, opb;
  logic [1:0]        sh;
  logic              sub, last_term;
  logic [R_W-1:0]    u_odd;
  logic [LIMB_W-1:0] ab_limb;
  logic [ACC_W-1:0]  shifted;
  logic [STATUS_W-1:0] chk_status;
  logic              out_free;
  logic [R_W-1:0]    r_final;

  assign {s_ovf, s_cnt, s_sx, s_sy, s_sxx, s_syy, s_sxy} = q_data;
  assign n64   = WORD_W'(s_cnt);
  assign sx64  = WORD_W'(s_sx);
  assign sy64  = WORD_W'(s_sy);
  assign sxx64 = WORD_W'(s_sxx);
  assign syy64 = WORD_W'(s_syy);
  assign sxy64 = WORD_W'(s_sxy);

  assign u_odd   = R_W'(({1'b0, mid} << 1) - 17'd1);
  assign ab_limb = ab[LIMB_W*term[1:0] +: LIMB_W];

  // Word sources for each job.
  always_comb begin
    wp = n64;
    wq = sxy64;
    wu = sx64;
    wv = sy64;
    case (job)
      JOB_A: begin
        wq = sxx64;
        wv = sx64;
      end
      JOB_B: begin
        wq = syy64;
        wu = sy64;
      end
      JOB_AB: begin
        wp = a_word;
        wq = b_word;
      end
      JOB_CC: begin
        wp = mag;
        wq = mag;
      end
      default: begin
      end
    endcase
  end

  // Limb product schedule of each job.
  always_comb begin
    opa       = wp[LIMB_W-1:0];
    opb       = wq[LIMB_W-1:0];
    sh        = 2'd0;
    sub       = 1'b0;
    last_term = 1'b0;
    unique case (job)
      JOB_C, JOB_A, JOB_B: begin
        // Low 64 bits of p*q - u*v.
        unique case (term)
          3'd0: begin
          end
          3'd1: begin
            opb = wq[WORD_W-1:LIMB_W];
            sh  = 2'd1;
          end
          3'd2: begin
            opa = wp[WORD_W-1:LIMB_W];
            sh  = 2'd1;
          end
          3'd3: begin
            opa = wu[LIMB_W-1:0];
            opb = wv[LIMB_W-1:0];
            sub = 1'b1;
          end
          3'd4: begin
            opa = wu[LIMB_W-1:0];
            opb = wv[WORD_W-1:LIMB_W];
            sh  = 2'd1;
            sub = 1'b1;
          end
          default: begin
            opa       = wu[WORD_W-1:LIMB_W];
            opb       = wv[LIMB_W-1:0];
            sh        = 2'd1;
            sub       = 1'b1;
            last_term = 1'b1;
          end
        endcase
      end
      JOB_AB, JOB_CC: begin
        // Full 128-bit product p*q.
        unique case (term[1:0])
          2'd0: begin
          end
          2'd1: begin
            opb = wq[WORD_W-1:LIMB_W];
            sh  = 2'd1;
          end
          2'd2: begin
            opa = wp[WORD_W-1:LIMB_W];
            sh  = 2'd1;
          end
          default: begin
            opa       = wp[WORD_W-1:LIMB_W];
            opb       = wq[WORD_W-1:LIMB_W];
            sh        = 2'd2;
            last_term = 1'b1;
          end
        endcase
      end
      JOB_T: begin
        // Square of the odd candidate 2*mid-1.
        opa       = LIMB_W'(u_odd);
        opb       = LIMB_W'(u_odd);
        last_term = 1'b1;
      end
      default: begin
        // Candidate square times A*B, one limb of A*B per term.
        opa       = t_word;
        opb       = ab_limb;
        sh        = term[1:0];
        last_term = term[1:0] == 2'd3;
      end
    endcase
  end

  assign shifted = ACC_W'(prod) << (LIMB_W * sh);

  assign chk_status = s_ovf ? ST_TOO_MANY :
                      (a_word == '0 || b_word == '0) ? ST_ZERO_VAR : ST_OK;

  assign out_free = !out_valid || !out_stall;
  assign q_pop    = state == S_DONE && out_free;

  always_comb begin
    if (res_status != ST_OK) begin
      r_final = '0;
    end else if (neg) begin
      r_final = R_W'(0) - lo;
    end else begin
      r_final = (lo > R_MAX) ? R_MAX : lo;
    end
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (q_valid) state_next = S_MUL;
      end
      S_MUL: begin
        state_next = S_ACC;
      end
      S_ACC: begin
        state_next = last_term ? S_STORE : S_MUL;
      end
      S_STORE: begin
        case (job) inside
          JOB_B:          state_next = S_CHECK;
          JOB_CC, JOB_L:  state_next = S_SEARCH;
          default:        state_next = S_MUL;
        endcase
      end
      S_CHECK: begin
        state_next = (chk_status == ST_OK) ? S_MUL : S_DONE;
      end
      S_SEARCH: begin
        state_next = (lo < hi) ? S_MUL : S_DONE;
      end
      S_DONE: begin
        if (out_free) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Sequencer datapath.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        job  <= JOB_C;
        term <= '0;
        acc  <= '0;
      end
      S_MUL: begin
        prod <= opa * opb;
      end
      S_ACC: begin
        acc  <= sub ? acc - shifted : acc + shifted;
        term <= term + 1'b1;
      end
      S_STORE: begin
        term <= '0;
        acc  <= '0;
        case (job)
          JOB_C: begin
            c_word <= acc[WORD_W-1:0];
            job    <= JOB_A;
          end
          JOB_A: begin
            a_word <= acc[WORD_W-1:0];
            job    <= JOB_B;
          end
          JOB_B: begin
            b_word <= acc[WORD_W-1:0];
          end
          JOB_AB: begin
            ab  <= acc[WIDE_W-1:0];
            job <= JOB_CC;
          end
          JOB_CC: begin
            cc <= acc[WIDE_W-1:0];
          end
          JOB_T: begin
            t_word <= acc[LIMB_W-1:0];
            job    <= JOB_L;
          end
          default: begin
            // Keep mid when (2*mid-1)^2 * A*B <= C^2 * 2^32.
            if (acc <= {cc, {LIMB_W{1'b0}}}) begin
              lo <= mid;
            end else begin
              hi <= mid - 1'b1;
            end
          end
        endcase
      end
      S_CHECK: begin
        res_status <= chk_status;
        neg        <= c_word[WORD_W-1];
        mag        <= c_word[WORD_W-1] ? WORD_W'(0) - c_word : c_word;
        lo         <= '0;
        hi         <= SEARCH_HI;
        job        <= JOB_AB;
      end
      S_SEARCH: begin
        mid <= R_W'(({1'b0, lo} + {1'b0, hi} + 17'd1) >> 1);
        job <= JOB_T;
      end
      default: begin
      end
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_pop) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (q_pop) begin
      r_value <= $signed(r_final);
      status  <= res_status;
    end
  end

endmodule

[rtl/pearson_correlation_unit.sv]
// ----------------------------------------------------------------------------
// Pearson correlation unit
// Streams sample pairs, keeps running sums and emits r in signed Q1.15.
//
//   Channel  Signals                        Direction  Transfer
//   in       x_sample, y_sample, last       to unit    in_valid && !in_stall
//   out      r_value, status                from unit  out_valid && !out_stall
//
// Sample pairs are taken one per cycle; the front end stalls only when a
// finished series meets a full two-entry queue.
// Each result comes from the single 32x32 multiplier of the back end and
// the 15 to 16 steps of the magnitude search; a status other than ok ends
// the work before the search.
// Reset is synchronous and clears the sums, the queue and the sequencer.
// A stalled result holds in the output register while the back end moves on.
// ----------------------------------------------------------------------------
module pearson_correlation_unit #(
  parameter int MAX_SAMPLES = 1024,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [15:0]             x_sample,
  input  logic signed [15:0]             y_sample,
  input  logic                           last,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [pcc_pkg::R_W-1:0] r_value,
  output logic [pcc_pkg::STATUS_W-1:0]   status
);
  import pcc_pkg::*;

  localparam int SNAP_W = snap_w(SAMPLE_BITS, MAX_SAMPLES);

  logic              push, q_full, q_valid, q_pop;
  logic [SNAP_W-1:0] push_data, q_head;

  // Front end: products and running sums.
  pcc_front #(
    .MAX_SAMPLES(MAX_SAMPLES),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .x_sample (x_sample),
    .y_sample (y_sample),
    .last     (last),
    .push     (push),
    .push_data(push_data),
    .q_full   (q_full)
  );

  // Series snapshot queue.
  pcc_queue #(
    .WIDTH(SNAP_W)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_data(push_data),
    .full     (q_full),
    .valid    (q_valid),
    .head     (q_head),
    .pop      (q_pop)
  );

  // Back end: coefficient sequencer.
  pcc_back #(
    .MAX_SAMPLES(MAX_SAMPLES),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_data   (q_head),
    .q_pop    (q_pop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .r_value  (r_value),
    .status   (status)
  );

  // Any status other than ok carries a zero coefficient.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> r_value == '0)
    else $error("nonzero r with error status");

  // The input stalls only while the queue is full.
  assert property (@(posedge clk) disable iff (rst) in_stall |-> q_full)
    else $error("input stalled with queue space left");

  // The back end takes only an entry that is present.
  assert property (@(posedge clk) disable iff (rst) q_pop |-> q_valid)
    else $error("pop from empty queue");

endmodule
